/* hdl/bmf_pkg.sv */
// shared types and constants for the box mean filter
package bmf_pkg;

  localparam int PIX_W     = 8;
  localparam int COORD_W   = 8;
  localparam int DIM_W     = 9;
  localparam int KS_W      = 4;
  localparam int PHASE_W   = 10;
  localparam int SUM_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W = 3 * COORD_W;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_KERNEL = 15;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 9'd256;
  localparam logic [KS_W-1:0]  RST_KERNEL_SIZE  = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_KERNEL_SIZE  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    ACT_WRITE   = 1'b0,
    ACT_COMPUTE = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROW_START,
    S_ROW_WAIT,
    S_COL_START,
    S_COL_WAIT,
    S_SCAN,
    S_DRAIN,
    S_DIV_START,
    S_DIV_WAIT,
    S_OUT
  } seq_state_t;

endpackage

/* hdl/bmf_frame_ram.sv */
// frame store: one write port, one read port with registered read data
module bmf_frame_ram #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/bmf_serial_div.sv */
// restoring divider, one quotient bit per cycle, shared for modulo and mean
module bmf_serial_div #(
  parameter int NW = 16,
  parameter int DW = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] a_r;
  logic [DW-1:0] b_r;
  logic [DW-1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          take;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_r, a_r[NW-1]};
  assign take  = (trial >= {1'b0, b_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= dividend;
      b_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      a_r   <= {a_r[NW-2:0], take};
      rem_r <= take ? DW'(trial - {1'b0, b_r}) : trial[DW-1:0];
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = a_r;
  assign remainder = rem_r;

endmodule

/* hdl/box_mean_filter.sv */
// top level of the box mean filter: config registers, sequencer, window scan
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  cfg     | in        | cfg_we              | cfg_addr index, cfg_wdata value
//  in      | in        | in_tvalid/in_tready | tdata col,row,pixel_in; tuser action
//  out     | out       | out_tvalid/out_tready | tdata pixel_out
//
// a write request yields no result
// a compute request: two 16-step modulo passes on the
// shared serial divider fold the window origin, the scan reads one tap per cycle
// through the single read port of the frame store, then a 16-step divide
// rst_n is synchronous; it clears control state and sets the config registers
// to 256, 256 and 3; the frame store is not cleared
// a finished result waits in the output register while the next request is taken
module box_mean_filter #(
  parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_KERNEL = bmf_pkg::DEF_MAX_KERNEL
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [bmf_pkg::DIM_W-1:0]      cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bmf_pkg::IN_DATA_W-1:0]  in_tdata,   // col, row, pixel_in
  input  logic                           in_tuser,   // action
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bmf_pkg::PIX_W-1:0]      out_tdata   // pixel_out
);

  import bmf_pkg::*;

  localparam int COL_AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW     = COL_AW + ROW_AW;

  // reflect-101 position of a tap from its phase within one period
  function automatic logic [DIM_W-1:0] fold_tap(input logic [PHASE_W-1:0] t,
                                                input logic [DIM_W-1:0]   dim,
                                                input logic [PHASE_W-1:0] p);
    logic [PHASE_W-1:0] m;
    begin
      m = p - t;
      if (dim == DIM_W'(1)) begin
        fold_tap = '0;
      end else if (t < PHASE_W'(dim)) begin
        fold_tap = t[DIM_W-1:0];
      end else begin
        fold_tap = m[DIM_W-1:0];
      end
    end
  endfunction

  // advance a phase by one tap, wrapping at the period
  function automatic logic [PHASE_W-1:0] step_phase(input logic [PHASE_W-1:0] t,
                                                    input logic [DIM_W-1:0]   dim,
                                                    input logic [PHASE_W-1:0] p);
    begin
      if (dim == DIM_W'(1) || t == p - PHASE_W'(1)) begin
        step_phase = '0;
      end else begin
        step_phase = t + PHASE_W'(1);
      end
    end
  endfunction

  // configuration registers
  logic [DIM_W-1:0] frame_width_r;
  logic [DIM_W-1:0] frame_height_r;
  logic [KS_W-1:0]  kernel_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      kernel_size_r  <= RST_KERNEL_SIZE;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        CFG_KERNEL_SIZE:  kernel_size_r  <= cfg_wdata[KS_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // effective geometry: zero acts as one, oversize clamps to the maximum
  logic [DIM_W-1:0]   w_eff, h_eff;
  logic [KS_W-1:0]    ks_eff;
  logic [KS_W-2:0]    half;
  logic [2*KS_W-1:0]  ks_sq;
  logic [PHASE_W-1:0] p_w, p_h;
  logic [KS_W-1:0]    ks_last;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width_r;
    end
    if (frame_height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height_r;
    end
    if (kernel_size_r == '0) begin
      ks_eff = KS_W'(1);
    end else if (32'(kernel_size_r) > MAX_KERNEL) begin
      ks_eff = KS_W'(MAX_KERNEL);
    end else begin
      ks_eff = kernel_size_r;
    end
  end

  assign half    = ks_eff[KS_W-1:1];
  assign ks_sq   = ks_eff * ks_eff;
  assign ks_last = ks_eff - KS_W'(1);
  // reflect-101 period is 2*(dim-1); zero for a one-pixel dimension
  assign p_w     = PHASE_W'({w_eff, 1'b0}) - PHASE_W'(2);
  assign p_h     = PHASE_W'({h_eff, 1'b0}) - PHASE_W'(2);

  // request fields
  logic [COORD_W-1:0] in_col, in_row;
  logic [PIX_W-1:0]   in_pix;
  logic               in_acc;

  assign in_col = in_tdata[COORD_W-1:0];
  assign in_row = in_tdata[2*COORD_W-1:COORD_W];
  assign in_pix = in_tdata[3*COORD_W-1:2*COORD_W];
  assign in_acc = in_tvalid && in_tready;

  // window origin, signed: coordinate minus radius
  logic [PHASE_W-1:0] org_col, org_row, neg_col, neg_row;

  assign org_col = PHASE_W'(in_col) - PHASE_W'(half);
  assign org_row = PHASE_W'(in_row) - PHASE_W'(half);
  assign neg_col = PHASE_W'(0) - org_col;
  assign neg_row = PHASE_W'(0) - org_row;

  // sequencer
  seq_state_t state_r, state_nxt;

  logic                div_start, div_busy, div_done;
  logic [SUM_W-1:0]    div_a, div_q;
  logic [PHASE_W-1:0]  div_b, div_rem;
  logic                rd_en;
  logic [PIX_W-1:0]    rd_data;
  logic                out_load;
  logic                scan_last;

  logic [KS_W-1:0]     dx_r, dy_r;
  logic [PHASE_W-1:0]  tx_r, tx0_r, ty_r;
  logic [COORD_W-1:0]  col_abs_r, row_abs_r;
  logic                col_neg_r, row_neg_r;
  logic [SUM_W-1:0]    sum_r;
  logic                rd_vld_r;
  logic                out_valid_r;
  logic [PIX_W-1:0]    out_data_r;
  logic [PHASE_W-1:0]  fold_phase;

  assign scan_last = (dx_r == ks_last) && (dy_r == ks_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && action_t'(in_tuser) == ACT_COMPUTE) begin
          state_nxt = S_ROW_START;
        end
      end
      S_ROW_START: state_nxt = S_ROW_WAIT;
      S_ROW_WAIT: begin
        if (div_done) begin
          state_nxt = S_COL_START;
        end
      end
      S_COL_START: state_nxt = S_COL_WAIT;
      S_COL_WAIT: begin
        if (div_done) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:     state_nxt = S_DIV_START;
      S_DIV_START: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    rd_en     = 1'b0;
    out_load  = 1'b0;
    div_a     = sum_r;
    div_b     = PHASE_W'(ks_sq);
    case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_ROW_START: begin
        div_start = 1'b1;
        div_a     = SUM_W'(row_abs_r);
        div_b     = p_h;
      end
      S_COL_START: begin
        div_start = 1'b1;
        div_a     = SUM_W'(col_abs_r);
        div_b     = p_w;
      end
      S_SCAN:      rd_en = 1'b1;
      S_DIV_START: div_start = 1'b1;
      S_OUT:       out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // origin phase: |origin| mod period, mirrored for a negative origin
  always_comb begin
    if (state_r == S_ROW_WAIT) begin
      fold_phase = (row_neg_r && div_rem != '0) ? p_h - div_rem : div_rem;
    end else begin
      fold_phase = (col_neg_r && div_rem != '0) ? p_w - div_rem : div_rem;
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_neg_r <= org_row[PHASE_W-1];
      col_neg_r <= org_col[PHASE_W-1];
      row_abs_r <= org_row[PHASE_W-1] ? neg_row[COORD_W-1:0] : org_row[COORD_W-1:0];
      col_abs_r <= org_col[PHASE_W-1] ? neg_col[COORD_W-1:0] : org_col[COORD_W-1:0];
      dx_r      <= '0;
      dy_r      <= '0;
      sum_r     <= '0;
    end else begin
      if (state_r == S_ROW_WAIT && div_done) begin
        ty_r <= fold_phase;
      end
      if (state_r == S_COL_WAIT && div_done) begin
        tx_r  <= fold_phase;
        tx0_r <= fold_phase;
      end
      if (state_r == S_SCAN) begin
        if (dx_r == ks_last) begin
          dx_r <= '0;
          tx_r <= tx0_r;
          dy_r <= dy_r + KS_W'(1);
          ty_r <= step_phase(ty_r, h_eff, p_h);
        end else begin
          dx_r <= dx_r + KS_W'(1);
          tx_r <= step_phase(tx_r, w_eff, p_w);
        end
      end
      // tap data lands in the cycle after its read
      if (rd_vld_r) begin
        sum_r <= sum_r + SUM_W'(rd_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  // frame store
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;

  // writes outside the store are dropped
  assign wr_en   = in_acc && action_t'(in_tuser) == ACT_WRITE
                   && 32'(in_col) < MAX_WIDTH && 32'(in_row) < MAX_HEIGHT;
  assign wr_addr = {ROW_AW'(in_row), COL_AW'(in_col)};
  assign rd_addr = {ROW_AW'(fold_tap(ty_r, h_eff, p_h)),
                    COL_AW'(fold_tap(tx_r, w_eff, p_w))};

  bmf_frame_ram #(
    .AW (AW),
    .DW (PIX_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_pix),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // shared divider: origin folding and the final mean
  bmf_serial_div #(
    .NW (SUM_W),
    .DW (PHASE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= div_q[PIX_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_busy)
    else $error("request taken while divider busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_ROW_WAIT || state_r == S_COL_WAIT
                  || state_r == S_DIV_WAIT))
    else $error("divider finished outside a wait state");

  a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (dx_r <= ks_last && dy_r <= ks_last))
    else $error("window counter out of range");

  a_tap_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == S_SCAN))
    else $error("tap data without a scan read");

endmodule

/* test/testbench.sv */
// self-checking testbench for the box mean filter: stream requests, predicted means, checks
`timescale 1ns / 1ps

module testbench;
  import bmf_pkg::*;

  // index past the end of the register list, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // settle time, long enough for any compute request to finish its tail
  localparam int SETTLE_CYCLES = 300;
  // cycles with no handshake at all before the run is declared hung
  localparam int HANG_LIMIT    = 5000;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int PHASE_ITEMS   = 300;
  localparam int STORE_W       = DEF_MAX_WIDTH;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr   = '0;
  logic [DIM_W-1:0]     cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;   // col, row, pixel_in
  logic                 in_tuser   = 1'b0; // action
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [PIX_W-1:0]     out_tdata;         // pixel_out

  // predicts the window mean of every compute request and checks the results in order
  class window_mean_checker;
    bit [PIX_W-1:0] pixels [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
    bit [DIM_W-1:0] width_reg;
    bit [DIM_W-1:0] height_reg;
    bit [KS_W-1:0]  kernel_reg;
    bit [PIX_W-1:0] pending_means [$];
    int             mismatches;

    function new();
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      kernel_reg = RST_KERNEL_SIZE;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg  = value;
        CFG_FRAME_HEIGHT: height_reg = value;
        CFG_KERNEL_SIZE:  kernel_reg = value[KS_W-1:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, anything past the maximum as the maximum
    function int width_eff();
      return (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(width_reg);
    endfunction

    function int height_eff();
      return (height_reg == 0) ? 1 :
             (height_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(height_reg);
    endfunction

    function int kernel_eff();
      return (kernel_reg == 0) ? 1 :
             (kernel_reg > DEF_MAX_KERNEL) ? DEF_MAX_KERNEL : int'(kernel_reg);
    endfunction

    // reflect-101 with period 2*(dim-1), repeated until the tap is in range
    function int fold_tap(int idx, int dim);
      int period;
      int m;
      if (dim <= 1) return 0;
      period = 2 * (dim - 1);
      m = idx % period;
      if (m < 0) m += period;
      if (m >= dim) m = period - m;
      return m;
    endfunction

    function void note_request(action_t act, bit [7:0] col, bit [7:0] row, bit [7:0] pix);
      int span;
      int half;
      int ry;
      int rx;
      int unsigned total;
      if (act == ACT_WRITE) begin
        pixels[{row, col}] = pix;
        return;
      end
      span  = kernel_eff();
      half  = span / 2;
      total = 0;
      for (int dy = 0; dy < span; dy++) begin
        ry = fold_tap(int'(row) - half + dy, height_eff());
        for (int dx = 0; dx < span; dx++) begin
          rx = fold_tap(int'(col) - half + dx, width_eff());
          total += pixels[ry * STORE_W + rx];
        end
      end
      pending_means.push_back(PIX_W'(total / (span * span)));
    endfunction

    function void check_mean(logic [PIX_W-1:0] got);
      bit [PIX_W-1:0] want;
      if (pending_means.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result pixel_out=%0d", got);
        return;
      end
      want = pending_means.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("pixel_out mismatch: expected %0d, got %0d", want, got);
      end
    endfunction

    function int pending_count();
      return pending_means.size();
    endfunction
  endclass

  window_mean_checker sb = new();

  bit tap_written [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
  bit idling_on     = 1'b1;
  int requests_sent = 0;
  int idle_cycles   = 0;

  box_mean_filter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver back-pressure, changed on the falling edge like every other input
  always @(negedge clk) begin
    out_tready <= idling_on ? ($urandom_range(99) >= 17) : 1'b1;
  end

  // sample both handshakes on the rising edge; also the hang watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_request(action_t'(in_tuser), in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);
      if (out_tvalid && out_tready)
        sb.check_mean(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // push_request and write_reg start on a falling edge and return just after the rising edge
  // that took their request, so valid is never lowered and raised in one step
  task automatic push_request(action_t act, logic [7:0] col, logic [7:0] row, logic [7:0] pix);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idling_on) begin
      while ($urandom_range(99) < 17) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {pix, row, col};
    do @(posedge clk); while (in_tready !== 1'b1);
    if (act == ACT_WRITE) tap_written[{row, col}] = 1'b1;
    requests_sent++;
  endtask

  // only legal while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // hold off the sender until every pending mean is back; settle lets a trailing
  // pixel write or a stray compute finish before the registers are touched
  task automatic drain_results(bit settle);
    @(negedge clk);
    in_tvalid <= 1'b0;
    cfg_we    <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // load every tap the window will fold onto before asking for the mean,
  // so no unwritten pixel is ever read
  task automatic compute_at(logic [7:0] col, logic [7:0] row);
    int span;
    int half;
    int ry;
    int rx;
    int dy;
    int dx;
    span = sb.kernel_eff();
    half = span / 2;
    for (dy = 0; dy < span; dy++) begin
      ry = sb.fold_tap(int'(row) - half + dy, sb.height_eff());
      for (dx = 0; dx < span; dx++) begin
        rx = sb.fold_tap(int'(col) - half + dx, sb.width_eff());
        if (!tap_written[ry * STORE_W + rx])
          push_request(ACT_WRITE, 8'(rx), 8'(ry), 8'($urandom_range(255)));
      end
    end
    push_request(ACT_COMPUTE, col, row, 8'($urandom_range(255)));
  endtask

  // dimension values: mostly small frames, with zero, full size and oversized now and then
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return 9'd1;
      1:       return 9'd256;
      2:       return 9'd0;
      3:       return 9'($urandom_range(257, 511));
      4, 5, 6: return 9'($urandom_range(2, 12));
      7, 8:    return 9'($urandom_range(13, 64));
      default: return 9'($urandom_range(65, 256));
    endcase
  endfunction

  // kernel side in the low bits, junk above them that the register must drop
  function automatic logic [DIM_W-1:0] pick_kernel();
    logic [KS_W-1:0] side;
    case ($urandom_range(7))
      0:       side = 4'd15;
      1:       side = 4'd0;
      2:       side = 4'd1;
      default: side = 4'($urandom_range(1, 7));
    endcase
    return {5'($urandom_range(31)), side};
  endfunction

  initial begin
    int phase_no;
    int phase_start;
    int ops;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // corner windows at reset settings: a bright top-left, a dark bottom-right
    push_request(ACT_WRITE, 8'd0, 8'd0, 8'd255);
    push_request(ACT_WRITE, 8'd1, 8'd0, 8'd255);
    push_request(ACT_WRITE, 8'd0, 8'd1, 8'd255);
    push_request(ACT_WRITE, 8'd1, 8'd1, 8'd255);
    push_request(ACT_COMPUTE, 8'd0, 8'd0, 8'd0);
    push_request(ACT_WRITE, 8'd254, 8'd254, 8'd0);
    push_request(ACT_WRITE, 8'd255, 8'd254, 8'd0);
    push_request(ACT_WRITE, 8'd254, 8'd255, 8'd0);
    push_request(ACT_WRITE, 8'd255, 8'd255, 8'd0);
    push_request(ACT_COMPUTE, 8'd255, 8'd255, 8'd255);

    // zero dimensions and zero kernel: a single-pixel frame, position far outside it
    drain_results(1'b1);
    write_reg(CFG_FRAME_WIDTH, 9'd0);
    write_reg(CFG_FRAME_HEIGHT, 9'd0);
    write_reg(CFG_KERNEL_SIZE, 9'd0);
    write_reg(CFG_UNUSED, 9'h1FF);
    push_request(ACT_COMPUTE, 8'd255, 8'd255, 8'd0);
    // largest kernel on a one-pixel frame: the largest window sum
    drain_results(1'b1);
    write_reg(CFG_KERNEL_SIZE, 9'd15);
    push_request(ACT_COMPUTE, 8'd128, 8'd7, 8'd0);

    // radius far beyond a 2x2 frame, folding wraps round many times
    drain_results(1'b1);
    write_reg(CFG_FRAME_WIDTH, 9'd2);
    write_reg(CFG_FRAME_HEIGHT, 9'd2);
    push_request(ACT_WRITE, 8'd1, 8'd0, 8'd0);
    push_request(ACT_COMPUTE, 8'd1, 8'd1, 8'd0);

    // oversized dimensions clip to the store, kernel register keeps its low bits only
    drain_results(1'b1);
    write_reg(CFG_FRAME_WIDTH, 9'd511);
    write_reg(CFG_FRAME_HEIGHT, 9'd300);
    write_reg(CFG_KERNEL_SIZE, 9'h1F1);
    push_request(ACT_WRITE, 8'd255, 8'd0, 8'h5A);
    push_request(ACT_COMPUTE, 8'd255, 8'd0, 8'hA5);

    // random phases, each with a fresh setting; a quiet stretch with no idling
    phase_no = 0;
    while (requests_sent < RANDOM_ITEMS + 16) begin
      drain_results(1'b1);
      idling_on = !(phase_no == 1 || phase_no == 2);
      write_reg(CFG_FRAME_WIDTH, pick_dim());
      write_reg(CFG_FRAME_HEIGHT, pick_dim());
      write_reg(CFG_KERNEL_SIZE, pick_kernel());
      if ($urandom_range(4) == 0) write_reg(CFG_UNUSED, 9'($urandom_range(511)));
      ops = $urandom_range(20, 80);
      phase_start = requests_sent;
      // a phase also ends once its share of requests or the whole run is used up
      for (int op = 0; op < ops && requests_sent - phase_start < PHASE_ITEMS
                       && requests_sent < RANDOM_ITEMS + 16; op++) begin
        // sender holds off mid-phase until the pipe is empty
        if (op == ops / 2 && (phase_no == 2 || $urandom_range(3) == 0))
          drain_results(1'b0);
        if ($urandom_range(99) < 55) begin
          // mostly inside the frame, sometimes anywhere the fields reach
          if ($urandom_range(4) == 0)
            compute_at(8'($urandom_range(255)), 8'($urandom_range(255)));
          else
            compute_at(8'($urandom_range(sb.width_eff() - 1)),
                       8'($urandom_range(sb.height_eff() - 1)));
        end else if ($urandom_range(9) < 7) begin
          push_request(ACT_WRITE, 8'($urandom_range(sb.width_eff() - 1)),
                       8'($urandom_range(sb.height_eff() - 1)), 8'($urandom_range(255)));
        end else begin
          // anywhere in the store, also outside the configured frame
          push_request(ACT_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
        end
      end
      phase_no++;
    end

    drain_results(1'b1);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* box_mean_filter.f */
hdl/bmf_pkg.sv
hdl/bmf_frame_ram.sv
hdl/bmf_serial_div.sv
hdl/box_mean_filter.sv
test/testbench.sv
